// ----- hdl/rss_pkg.sv -----
// Shared types and constants for the recycled slot stack.
package rss_pkg;

  localparam int DEF_STACK_DEPTH = 1024;
  localparam int CNT_W           = 11;
  localparam int LOC_W           = 32;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [LOC_W-1:0] slot_block;
    logic [LOC_W-1:0] slot_offset;
  } rss_in_t;

  typedef struct packed {
    logic             found;
    logic [LOC_W-1:0] out_block;
    logic [LOC_W-1:0] out_offset;
    logic [CNT_W-1:0] removed_count;
    logic             overflow;
    logic [CNT_W-1:0] occupancy;
  } rss_out_t;

endpackage

// ----- hdl/rss_ram.sv -----
// Single write, single read port entry memory with registered read data.
module rss_ram #(
  parameter int DEPTH  = rss_pkg::DEF_STACK_DEPTH,
  parameter int DATA_W = 2 * rss_pkg::LOC_W,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/rss_ctrl.sv -----
// Command sequencer: push, pop and the compacting remove-block scan.
module rss_ctrl #(
  parameter int STACK_DEPTH = rss_pkg::DEF_STACK_DEPTH,
  parameter int AW          = $clog2(STACK_DEPTH),
  parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rss_pkg::rss_in_t              in_data,
  output logic                          res_valid,
  input  logic                          res_take,
  output rss_pkg::rss_out_t             res,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [2*rss_pkg::LOC_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [2*rss_pkg::LOC_W-1:0]   mem_rdata
);
  import rss_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_SCAN, ST_DONE} state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    wr_r, wr_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic             pend_r, pend_nxt;
  logic [LOC_W-1:0] tgt_r, tgt_nxt;
  logic             found_r, found_nxt;
  logic [LOC_W-1:0] blk_r, blk_nxt;
  logic [LOC_W-1:0] off_r, off_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CW-1:0]    cnt_dec;
  logic             match;
  logic [CW+CNT_W-1:0] occ_ext;
  logic [CW+CNT_W-1:0] rem_ext;

  assign cnt_dec = count_r - 1'b1;
  // block comparator for the scan
  assign match   = (mem_rdata[2*LOC_W-1:LOC_W] == tgt_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    rem_nxt   = rem_r;
    pend_nxt  = pend_r;
    tgt_nxt   = tgt_r;
    found_nxt = found_r;
    blk_nxt   = blk_r;
    off_nxt   = off_r;
    ovf_nxt   = ovf_r;
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = {in_data.slot_block, in_data.slot_offset};
    mem_re    = 1'b0;
    mem_raddr = rd_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          found_nxt = 1'b0;
          blk_nxt   = '0;
          off_nxt   = '0;
          ovf_nxt   = 1'b0;
          rem_nxt   = '0;
          tgt_nxt   = in_data.slot_block;
          state_nxt = ST_DONE;
          case (in_data.command)
            CMD_PUSH: begin
              if (count_r < DEPTH_C) begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_POP: begin
              if (count_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = cnt_dec[AW-1:0];
                count_nxt = cnt_dec;
                state_nxt = ST_POP;
              end
            end
            CMD_REMOVE: begin
              rd_nxt    = '0;
              wr_nxt    = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        found_nxt = 1'b1;
        blk_nxt   = mem_rdata[2*LOC_W-1:LOC_W];
        off_nxt   = mem_rdata[LOC_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (pend_r) begin
          if (match) begin
            rem_nxt = rem_r + 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_r[AW-1:0];
            mem_wdata = mem_rdata;
            wr_nxt    = wr_r + 1'b1;
          end
        end
        if (rd_r < count_r) begin
          mem_re   = 1'b1;
          rd_nxt   = rd_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = wr_r;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    rd_r    <= rd_nxt;
    wr_r    <= wr_nxt;
    rem_r   <= rem_nxt;
    tgt_r   <= tgt_nxt;
    found_r <= found_nxt;
    blk_r   <= blk_nxt;
    off_r   <= off_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  assign occ_ext = {{CNT_W{1'b0}}, count_r};
  assign rem_ext = {{CNT_W{1'b0}}, rem_r};

  always_comb begin
    res.found         = found_r;
    res.out_block     = blk_r;
    res.out_offset    = off_r;
    res.removed_count = rem_ext[CNT_W-1:0];
    res.overflow      = ovf_r;
    res.occupancy     = occ_ext[CNT_W-1:0];
  end

endmodule

// ----- hdl/recycled_slot_stack.sv -----
// Recycled slot stack top level: sequencer, entry memory and output register.
// LIFO of free slot locations held in a single-port-write, single-port-read memory
// of STACK_DEPTH entries. One command is in progress at a time. A pop returns
// the top entry through one registered memory read; a remove-block runs a scan
// that reads one entry a cycle, compares its block and writes survivors back
// down in order.
// Results sit in an output register, so the next command is taken while a
// result still waits. No clearing pass is needed after reset.
module recycled_slot_stack #(
  parameter int STACK_DEPTH = rss_pkg::DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rss_pkg::rss_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rss_pkg::rss_out_t out_data
);
  import rss_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic               res_valid;
  logic               res_take;
  rss_out_t           res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [2*LOC_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [2*LOC_W-1:0] mem_rdata;
  logic               out_valid_r;
  rss_out_t           out_data_r;

  rss_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rss_ram #(
    .DEPTH  (STACK_DEPTH),
    .DATA_W (2 * LOC_W),
    .AW     (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
